[hw/rtl/psq_pkg.sv]
// ----------------------------------------------------------------------------
// psq_pkg
// Shared types and codes for the pressurization sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

    localparam int unsigned PRESS_W  = 16;
    localparam int unsigned LIMIT_W  = 15;
    localparam int unsigned DWELL_W  = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned APB_AW   = 5;
    localparam int unsigned APB_DW   = 32;

    // Reset values of the configuration registers
    localparam logic [LIMIT_W-1:0] ARM_MAX_RST   = 15'd100;
    localparam logic [LIMIT_W-1:0] SP_MIN_RST    = 15'd500;
    localparam logic [LIMIT_W-1:0] SP_MAX_RST    = 15'd1500;
    localparam logic [LIMIT_W-1:0] HOLD_BAND_RST = 15'd50;
    localparam logic [LIMIT_W-1:0] EMPTY_RST     = 15'd50;
    localparam logic [DWELL_W-1:0] DWELL_RST     = 16'd2000;

    typedef enum logic [2:0] {
        REG_ARM_MAX   = 3'd0,
        REG_SP_MIN    = 3'd1,
        REG_SP_MAX    = 3'd2,
        REG_HOLD_BAND = 3'd3,
        REG_EMPTY     = 3'd4,
        REG_DWELL     = 3'd5
    } reg_idx_t;

    typedef enum logic {
        OP_COMMAND = 1'b0,
        OP_TICK    = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        CMD_ARM    = 3'd0,
        CMD_DISARM = 3'd1,
        CMD_SET    = 3'd2,
        CMD_PRESS  = 3'd3,
        CMD_VENT   = 3'd4,
        CMD_CLEAR  = 3'd5,
        CMD_ABORT  = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_ARMED = 3'd1,
        MODE_PRESS = 3'd2,
        MODE_HOLD  = 3'd3,
        MODE_VENT  = 3'd4,
        MODE_SAFE  = 3'd5,
        MODE_ABORT = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_WRONG = 3'd1,
        ST_FAULT = 3'd2,
        ST_RANGE = 3'd3,
        ST_TICK  = 3'd4
    } status_t;

    typedef struct packed {
        logic                       op;
        logic [2:0]                 command;
        logic signed [PRESS_W-1:0]  setpoint_arg;
        logic signed [PRESS_W-1:0]  pressure;
        logic                       loop_fault;
        logic                       overpressure;
        logic                       stale;
        logic [TIME_W-1:0]          now_ms;
    } in_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] state_now;
        logic       fault_flag;
        logic       setpoint_valid;
    } out_word_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] arm_max_pressure;
        logic [LIMIT_W-1:0] setpoint_min;
        logic [LIMIT_W-1:0] setpoint_max;
        logic [LIMIT_W-1:0] hold_band;
        logic [LIMIT_W-1:0] empty_pressure;
        logic [DWELL_W-1:0] dwell_time;
    } cfg_t;

    typedef struct packed {
        mode_t                      mode;
        logic                       fault_latch;
        logic signed [PRESS_W-1:0]  target_pressure;
        logic                       target_valid;
        logic                       dwell_running;
        logic [TIME_W-1:0]          dwell_start;
    } seq_state_t;

endpackage

`default_nettype wire

[hw/rtl/psq_in_if.sv]
// ----------------------------------------------------------------------------
// psq_in_if
// Valid/ready channel carrying one command or tick word.
// ----------------------------------------------------------------------------
`default_nettype none

interface psq_in_if;
    logic               valid;
    logic               ready;
    psq_pkg::in_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/psq_out_if.sv]
// ----------------------------------------------------------------------------
// psq_out_if
// Valid/ready channel carrying one status word.
// ----------------------------------------------------------------------------
`default_nettype none

interface psq_out_if;
    logic               valid;
    logic               ready;
    psq_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/psq_step.sv]
// ----------------------------------------------------------------------------
// psq_step
// Next-state and status logic for one word: command checks, redline, dwell.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_step (
    input  wire psq_pkg::in_word_t   word,
    input  wire psq_pkg::seq_state_t cur,
    input  wire psq_pkg::cfg_t       cfg,
    output psq_pkg::seq_state_t      nxt,
    output psq_pkg::out_word_t       result
);

    logic signed [17:0] p18;
    logic signed [17:0] tgt18;
    logic signed [17:0] band_lo;
    logic signed [17:0] band_hi;
    logic signed [16:0] p17;
    logic signed [16:0] arg17;
    logic               below_arm;
    logic               in_band;
    logic               empty;
    logic               sp_ok;
    logic               redline;
    logic [31:0]        elapsed;
    logic               expired;
    logic               dw_cond;
    logic               dw_clear_miss;
    psq_pkg::mode_t     dw_next;
    psq_pkg::status_t   status;

    // Signed compares against unsigned 15-bit limits, widened to stay exact
    assign p17       = {word.pressure[15], word.pressure};
    assign arg17     = {word.setpoint_arg[15], word.setpoint_arg};
    assign p18       = {{2{word.pressure[15]}}, word.pressure};
    assign tgt18     = {{2{cur.target_pressure[15]}}, cur.target_pressure};
    assign band_lo   = tgt18 - $signed({3'b000, cfg.hold_band});
    assign band_hi   = tgt18 + $signed({3'b000, cfg.hold_band});
    assign below_arm = p17 < $signed({2'b00, cfg.arm_max_pressure});
    assign empty     = p17 <= $signed({2'b00, cfg.empty_pressure});
    assign in_band   = (p18 >= band_lo) && (p18 <= band_hi);
    assign sp_ok     = (arg17 >= $signed({2'b00, cfg.setpoint_min}))
                    && (arg17 <= $signed({2'b00, cfg.setpoint_max}));
    assign redline   = word.overpressure || word.loop_fault;

    // Wrapping elapsed time
    assign elapsed   = word.now_ms - cur.dwell_start;
    assign expired   = elapsed >= {16'd0, cfg.dwell_time};

    // Dwell condition per mode
    always_comb
    begin
        dw_cond       = 1'b0;
        dw_clear_miss = 1'b0;
        dw_next       = psq_pkg::MODE_SAFE;
        case (cur.mode)
            psq_pkg::MODE_PRESS:
            begin
                dw_cond       = in_band;
                dw_clear_miss = 1'b1;
                dw_next       = psq_pkg::MODE_HOLD;
            end
            psq_pkg::MODE_VENT:
            begin
                dw_cond       = empty;
                dw_clear_miss = 1'b0;
            end
            psq_pkg::MODE_ABORT:
            begin
                dw_cond       = !word.stale && empty;
                dw_clear_miss = 1'b1;
            end
            default:
            begin
                dw_cond       = 1'b0;
                dw_clear_miss = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        nxt    = cur;
        status = psq_pkg::ST_WRONG;
        if (word.op == psq_pkg::OP_COMMAND)
        begin
            unique case (word.command)
                psq_pkg::CMD_ARM:
                begin
                    if (cur.mode != psq_pkg::MODE_IDLE)
                        status = psq_pkg::ST_WRONG;
                    else if (cur.fault_latch)
                        status = psq_pkg::ST_FAULT;
                    else if (!below_arm || word.loop_fault)
                        status = psq_pkg::ST_RANGE;
                    else
                    begin
                        nxt.mode          = psq_pkg::MODE_ARMED;
                        nxt.dwell_running = 1'b0;
                        status            = psq_pkg::ST_OK;
                    end
                end
                psq_pkg::CMD_DISARM:
                begin
                    if (cur.mode != psq_pkg::MODE_ARMED)
                        status = psq_pkg::ST_WRONG;
                    else
                    begin
                        nxt.mode          = psq_pkg::MODE_IDLE;
                        nxt.dwell_running = 1'b0;
                        status            = psq_pkg::ST_OK;
                    end
                end
                psq_pkg::CMD_SET:
                begin
                    if (!(cur.mode inside {psq_pkg::MODE_IDLE, psq_pkg::MODE_ARMED,
                                           psq_pkg::MODE_PRESS, psq_pkg::MODE_HOLD}))
                        status = psq_pkg::ST_WRONG;
                    else if (!sp_ok)
                        status = psq_pkg::ST_RANGE;
                    else
                    begin
                        nxt.target_pressure = word.setpoint_arg;
                        nxt.target_valid    = 1'b1;
                        status              = psq_pkg::ST_OK;
                    end
                end
                psq_pkg::CMD_PRESS:
                begin
                    if (cur.mode != psq_pkg::MODE_ARMED)
                        status = psq_pkg::ST_WRONG;
                    else if (cur.fault_latch)
                        status = psq_pkg::ST_FAULT;
                    else if (!below_arm || !cur.target_valid)
                        status = psq_pkg::ST_RANGE;
                    else
                    begin
                        nxt.mode          = psq_pkg::MODE_PRESS;
                        nxt.dwell_running = 1'b0;
                        status            = psq_pkg::ST_OK;
                    end
                end
                psq_pkg::CMD_VENT:
                begin
                    if (cur.mode != psq_pkg::MODE_PRESS && cur.mode != psq_pkg::MODE_HOLD)
                        status = psq_pkg::ST_WRONG;
                    else
                    begin
                        nxt.mode          = psq_pkg::MODE_VENT;
                        nxt.dwell_running = 1'b0;
                        status            = psq_pkg::ST_OK;
                    end
                end
                psq_pkg::CMD_CLEAR:
                begin
                    if (cur.mode != psq_pkg::MODE_SAFE)
                        status = psq_pkg::ST_WRONG;
                    else if (!below_arm)
                        status = psq_pkg::ST_RANGE;
                    else
                    begin
                        nxt.fault_latch     = 1'b0;
                        nxt.target_valid    = 1'b0;
                        nxt.target_pressure = '0;
                        nxt.mode            = psq_pkg::MODE_IDLE;
                        nxt.dwell_running   = 1'b0;
                        status              = psq_pkg::ST_OK;
                    end
                end
                psq_pkg::CMD_ABORT:
                begin
                    nxt.fault_latch   = 1'b1;
                    nxt.mode          = psq_pkg::MODE_ABORT;
                    nxt.dwell_running = 1'b0;
                    status            = psq_pkg::ST_OK;
                end
                default:
                begin
                    // unused command code: no effect
                    status = psq_pkg::ST_WRONG;
                end
            endcase
        end
        else
        begin
            status = psq_pkg::ST_TICK;
            if (redline && cur.mode != psq_pkg::MODE_ABORT)
            begin
                nxt.fault_latch   = 1'b1;
                nxt.mode          = psq_pkg::MODE_ABORT;
                nxt.dwell_running = 1'b0;
            end
            else if (dw_cond)
            begin
                if (!cur.dwell_running)
                begin
                    nxt.dwell_running = 1'b1;
                    nxt.dwell_start   = word.now_ms;
                end
                else if (expired)
                begin
                    nxt.mode          = dw_next;
                    nxt.dwell_running = 1'b0;
                end
            end
            else if (dw_clear_miss)
            begin
                nxt.dwell_running = 1'b0;
            end
        end
    end

    assign result.status         = status;
    assign result.state_now      = nxt.mode;
    assign result.fault_flag     = nxt.fault_latch;
    assign result.setpoint_valid = nxt.target_valid;

endmodule

`default_nettype wire

[hw/rtl/pressurization_sequencer.sv]
// ----------------------------------------------------------------------------
// pressurization_sequencer
// Path: input register, then step logic into the result register.
// Throughput: one word per cycle unless the status side stalls; the step is a
//   single pass of compare logic off the input register, with mode/latch/dwell
//   state updated in the same edge.
// Reset: rst_n async low; mode idle, latch and setpoint cleared, dwell stopped,
//   config registers to defaults, both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pressurization_sequencer (
    input  wire                               clk,
    input  wire                               rst_n,
    psq_in_if.sink                            in_ch,
    psq_out_if.source                         out_ch,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [psq_pkg::APB_AW-1:0]         paddr,
    input  wire [psq_pkg::APB_DW-1:0]         pwdata,
    output logic [psq_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    // ---- configuration registers ------------------------------------------
    psq_pkg::cfg_t       cfg_reg;
    psq_pkg::cfg_t       cfg_next;
    psq_pkg::reg_idx_t   cfg_idx;
    logic                cfg_wr;

    // ---- pipeline and sequencer state -------------------------------------
    logic                in_valid_reg;
    logic                in_valid_next;
    psq_pkg::in_word_t   in_data_reg;
    psq_pkg::in_word_t   in_data_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    psq_pkg::out_word_t  out_data_reg;
    psq_pkg::out_word_t  out_data_next;
    psq_pkg::seq_state_t state_reg;
    psq_pkg::seq_state_t state_next;
    psq_pkg::seq_state_t step_state;
    psq_pkg::out_word_t  step_result;
    logic                step_fire;
    logic                in_take;

    // APB: zero wait states; registers on word addresses
    assign pready  = 1'b1;
    assign cfg_idx = psq_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                psq_pkg::REG_ARM_MAX:   cfg_next.arm_max_pressure = pwdata[14:0];
                psq_pkg::REG_SP_MIN:    cfg_next.setpoint_min     = pwdata[14:0];
                psq_pkg::REG_SP_MAX:    cfg_next.setpoint_max     = pwdata[14:0];
                psq_pkg::REG_HOLD_BAND: cfg_next.hold_band        = pwdata[14:0];
                psq_pkg::REG_EMPTY:     cfg_next.empty_pressure   = pwdata[14:0];
                psq_pkg::REG_DWELL:     cfg_next.dwell_time       = pwdata[15:0];
                default:                cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            psq_pkg::REG_ARM_MAX:   prdata = {17'd0, cfg_reg.arm_max_pressure};
            psq_pkg::REG_SP_MIN:    prdata = {17'd0, cfg_reg.setpoint_min};
            psq_pkg::REG_SP_MAX:    prdata = {17'd0, cfg_reg.setpoint_max};
            psq_pkg::REG_HOLD_BAND: prdata = {17'd0, cfg_reg.hold_band};
            psq_pkg::REG_EMPTY:     prdata = {17'd0, cfg_reg.empty_pressure};
            psq_pkg::REG_DWELL:     prdata = {16'd0, cfg_reg.dwell_time};
            default:                prdata = '0;
        endcase
    end

    // ---- handshake ---------------------------------------------------------
    // The step fires when a word sits in the input register and the result
    // register is free or being drained this cycle. The input register
    // refills in the same cycle it is consumed.
    assign step_fire    = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || step_fire;
    assign in_take      = in_ch.valid && in_ch.ready;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    psq_step u_step (
        .word   (in_data_reg),
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .nxt    (step_state),
        .result (step_result)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        state_next     = state_reg;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;
        if (step_fire)
        begin
            in_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = step_result;
            state_next     = step_state;
        end
        if (in_take)
        begin
            in_valid_next = 1'b1;
            in_data_next  = in_ch.data;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_max_pressure <= psq_pkg::ARM_MAX_RST;
            cfg_reg.setpoint_min     <= psq_pkg::SP_MIN_RST;
            cfg_reg.setpoint_max     <= psq_pkg::SP_MAX_RST;
            cfg_reg.hold_band        <= psq_pkg::HOLD_BAND_RST;
            cfg_reg.empty_pressure   <= psq_pkg::EMPTY_RST;
            cfg_reg.dwell_time       <= psq_pkg::DWELL_RST;
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            state_reg.mode           <= psq_pkg::MODE_IDLE;
            state_reg.fault_latch    <= 1'b0;
            state_reg.target_pressure <= '0;
            state_reg.target_valid   <= 1'b0;
            state_reg.dwell_running  <= 1'b0;
            state_reg.dwell_start    <= '0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

[bench/psq_status_checker.sv]
// ----------------------------------------------------------------------------
// psq_status_checker
// Watches the command/tick channel, the status channel and the register port.
// It predicts the status word that each accepted input word should produce,
// queues the predictions in order, and compares every accepted status word
// field by field against the oldest one.
// ----------------------------------------------------------------------------
module psq_status_checker
    import psq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    psq_in_if                 in_ch,
    psq_out_if                out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                fail_count,
    output int                pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t                      limits;
    mode_t                     seq_mode    = MODE_IDLE;
    logic                      latched     = 1'b0;
    logic signed [PRESS_W-1:0] target_sp   = '0;
    logic                      target_ok   = 1'b0;
    logic                      dwell_on    = 1'b0;
    logic [TIME_W-1:0]         dwell_t0    = '0;
    out_word_t                 status_due[$];
    int                        errors      = 0;

    task automatic reset_model();
        limits.arm_max_pressure = ARM_MAX_RST;
        limits.setpoint_min     = SP_MIN_RST;
        limits.setpoint_max     = SP_MAX_RST;
        limits.hold_band        = HOLD_BAND_RST;
        limits.empty_pressure   = EMPTY_RST;
        limits.dwell_time       = DWELL_RST;
        seq_mode  = MODE_IDLE;
        latched   = 1'b0;
        target_sp = '0;
        target_ok = 1'b0;
        dwell_on  = 1'b0;
        dwell_t0  = '0;
    endtask

    task automatic write_limit(input logic [2:0] idx, input logic [APB_DW-1:0] value);
        case (idx)
            REG_ARM_MAX:   limits.arm_max_pressure = value[LIMIT_W-1:0];
            REG_SP_MIN:    limits.setpoint_min     = value[LIMIT_W-1:0];
            REG_SP_MAX:    limits.setpoint_max     = value[LIMIT_W-1:0];
            REG_HOLD_BAND: limits.hold_band        = value[LIMIT_W-1:0];
            REG_EMPTY:     limits.empty_pressure   = value[LIMIT_W-1:0];
            REG_DWELL:     limits.dwell_time       = value[DWELL_W-1:0];
            default:       ;
        endcase
    endtask

    // any mode entry, re-entry included, drops the dwell timer
    function automatic void enter_mode(input mode_t next);
        seq_mode = next;
        dwell_on = 1'b0;
    endfunction

    function automatic void dwell_advance(input logic cond, input logic drop_on_miss,
                                          input logic [TIME_W-1:0] now, input mode_t next);
        logic [TIME_W-1:0] elapsed;
        elapsed = now - dwell_t0;
        if (cond) begin
            if (!dwell_on) begin
                dwell_on = 1'b1;
                dwell_t0 = now;
            end
            else if (elapsed >= {16'd0, limits.dwell_time}) begin
                enter_mode(next);
            end
        end
        else if (drop_on_miss) begin
            dwell_on = 1'b0;
        end
    endfunction

    function automatic out_word_t predict_status(input in_word_t w);
        int        p_val;
        int        arg_val;
        int        arm_lim;
        int        empty_lim;
        int        tgt;
        int        band;
        status_t   st;
        out_word_t res;
        p_val     = int'($signed(w.pressure));
        arg_val   = int'($signed(w.setpoint_arg));
        arm_lim   = int'(limits.arm_max_pressure);
        empty_lim = int'(limits.empty_pressure);
        tgt       = int'(target_sp);
        band      = int'(limits.hold_band);
        st        = ST_WRONG;
        if (w.op == OP_COMMAND) begin
            case (w.command)
                CMD_ARM: begin
                    if (seq_mode != MODE_IDLE) st = ST_WRONG;
                    else if (latched) st = ST_FAULT;
                    else if (p_val >= arm_lim || w.loop_fault) st = ST_RANGE;
                    else begin
                        enter_mode(MODE_ARMED);
                        st = ST_OK;
                    end
                end
                CMD_DISARM: begin
                    if (seq_mode != MODE_ARMED) st = ST_WRONG;
                    else begin
                        enter_mode(MODE_IDLE);
                        st = ST_OK;
                    end
                end
                CMD_SET: begin
                    if (!(seq_mode inside {MODE_IDLE, MODE_ARMED, MODE_PRESS, MODE_HOLD}))
                        st = ST_WRONG;
                    else if (arg_val < int'(limits.setpoint_min) ||
                             arg_val > int'(limits.setpoint_max))
                        st = ST_RANGE;
                    else begin
                        target_sp = w.setpoint_arg;
                        target_ok = 1'b1;
                        st = ST_OK;
                    end
                end
                CMD_PRESS: begin
                    if (seq_mode != MODE_ARMED) st = ST_WRONG;
                    else if (latched) st = ST_FAULT;
                    else if (p_val >= arm_lim || !target_ok) st = ST_RANGE;
                    else begin
                        enter_mode(MODE_PRESS);
                        st = ST_OK;
                    end
                end
                CMD_VENT: begin
                    if (!(seq_mode inside {MODE_PRESS, MODE_HOLD})) st = ST_WRONG;
                    else begin
                        enter_mode(MODE_VENT);
                        st = ST_OK;
                    end
                end
                CMD_CLEAR: begin
                    if (seq_mode != MODE_SAFE) st = ST_WRONG;
                    else if (p_val >= arm_lim) st = ST_RANGE;
                    else begin
                        latched   = 1'b0;
                        target_ok = 1'b0;
                        target_sp = '0;
                        enter_mode(MODE_IDLE);
                        st = ST_OK;
                    end
                end
                CMD_ABORT: begin
                    latched = 1'b1;
                    enter_mode(MODE_ABORT);
                    st = ST_OK;
                end
                default: st = ST_WRONG;
            endcase
        end
        else begin
            st = ST_TICK;
            if ((w.overpressure || w.loop_fault) && seq_mode != MODE_ABORT) begin
                latched = 1'b1;
                enter_mode(MODE_ABORT);
            end
            else begin
                case (seq_mode)
                    MODE_PRESS: dwell_advance(p_val >= tgt - band && p_val <= tgt + band,
                                              1'b1, w.now_ms, MODE_HOLD);
                    MODE_VENT:  dwell_advance(p_val <= empty_lim, 1'b0, w.now_ms, MODE_SAFE);
                    MODE_ABORT: dwell_advance(!w.stale && p_val <= empty_lim, 1'b1,
                                              w.now_ms, MODE_SAFE);
                    default:    ;
                endcase
            end
        end
        res.status         = st;
        res.state_now      = seq_mode;
        res.fault_flag     = latched;
        res.setpoint_valid = target_ok;
        return res;
    endfunction

    task automatic check_field(input string field, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        out_word_t want;
        if (!rst_n) begin
            reset_model();
            status_due.delete();
        end
        else begin
            if (psel && penable && pwrite && pready)
                write_limit(paddr[4:2], pwdata);
            if (in_ch.valid && in_ch.ready)
                status_due.push_back(predict_status(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                if (status_due.size() == 0) begin
                    errors++;
                    $display("%0t: status word with none expected, expected nothing, actual %0h",
                             $time, out_ch.data);
                end
                else begin
                    want = status_due.pop_front();
                    check_field("status", want.status, out_ch.data.status);
                    check_field("state_now", want.state_now, out_ch.data.state_now);
                    check_field("fault_flag", want.fault_flag, out_ch.data.fault_flag);
                    check_field("setpoint_valid", want.setpoint_valid,
                                out_ch.data.setpoint_valid);
                end
            end
        end
        fail_count    <= errors;
        pending_words <= status_due.size();
    end

endmodule

[bench/pressurization_sequencer_test.sv]
// ----------------------------------------------------------------------------
// pressurization_sequencer_test
// Drives command and tick words into the sequencer under bursty input and a
// stalling output, rewrites the limit registers between phases (defaults,
// all-high extremes, all-low extremes, random), and leaves the checking to
// psq_status_checker. Prints the verdict once everything has drained.
// ----------------------------------------------------------------------------
module pressurization_sequencer_test;
    import psq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYCLES   = 7;
    localparam int          PHASE_WORDS    = 125;   // random words per limit setting
    localparam int          LONG_STALL     = 80;    // forced hold-off on the status side
    localparam int          DRAIN_CYCLES   = 8;     // settle margin after the last status word
    // Longest quiet stretch in a correct run: the forced hold-off plus a sender
    // gap plus a few register writes. Far below this.
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [2:0]  CMD_UNUSED     = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending_words;

    // stimulus-side view of the limits, used to shape well-formed sequences
    cfg_t                limits;
    logic [TIME_W-1:0]   clock_ms;
    int                  target_sp;
    int                  burst_left    = 0;
    int                  words_sent    = 0;
    bit                  stall_request = 1'b0;

    psq_in_if  in_ch ();
    psq_out_if out_ch ();

    pressurization_sequencer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    psq_status_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------

    // Clamp into the 16-bit signed pressure range, then pick inside [lo, hi].
    // Half the time the pick lands right on an edge of the window.
    function automatic int pick_between(input int lo, input int hi);
        int a;
        int b;
        a = (lo < -32768) ? -32768 : lo;
        b = (hi > 32767) ? 32767 : hi;
        if (a >= b)
            return a;
        case ($urandom_range(0, 3))
            0:       return a;
            1:       return b;
            default: return a + int'($urandom_range(0, b - a));
        endcase
    endfunction

    function automatic int pick_below(input int limit);
        return pick_between(-32768, limit - 1);
    endfunction

    // Command word; the fields a command ignores are left random.
    function automatic in_word_t cmd_word(input logic [2:0] code, input int arg,
                                          input int p, input bit lf);
        in_word_t w;
        w.op           = OP_COMMAND;
        w.command      = code;
        w.setpoint_arg = 16'(arg);
        w.pressure     = 16'(p);
        w.loop_fault   = lf;
        w.overpressure = 1'($urandom_range(0, 1));
        w.stale        = 1'($urandom_range(0, 1));
        w.now_ms       = $urandom;
        return w;
    endfunction

    function automatic in_word_t tick_word(input int p, input logic [TIME_W-1:0] now,
                                           input bit lf, input bit ovp, input bit stl);
        in_word_t w;
        w.op           = OP_TICK;
        w.command      = 3'($urandom_range(0, 7));
        w.setpoint_arg = 16'($urandom);
        w.pressure     = 16'(p);
        w.loop_fault   = lf;
        w.overpressure = ovp;
        w.stale        = stl;
        w.now_ms       = now;
        return w;
    endfunction

    // Anything at all, including the unused command code. Redline flags are
    // kept to one in four so noise does not abort every sequence.
    function automatic in_word_t noise_word();
        in_word_t w;
        w.op           = 1'($urandom_range(0, 1));
        w.command      = 3'($urandom_range(0, 7));
        w.setpoint_arg = 16'($urandom);
        w.pressure     = 16'($urandom);
        w.loop_fault   = ($urandom_range(0, 3) == 0);
        w.overpressure = ($urandom_range(0, 3) == 0);
        w.stale        = 1'($urandom_range(0, 1));
        w.now_ms       = $urandom;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them. valid is
    // only dropped when a gap actually follows, so back-to-back words keep
    // it high without a same-step low/high pair.
    // ------------------------------------------------------------------
    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge clk); while (!in_ch.ready);
        burst_left--;
        words_sent++;
    endtask

    // Occasionally slips a stray word in ahead, which breaks the sequence.
    task automatic offer(input in_word_t w);
        if ($urandom_range(0, 14) == 0)
            send_word(noise_word());
        send_word(w);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_ARM_MAX:   limits.arm_max_pressure = value[LIMIT_W-1:0];
            REG_SP_MIN:    limits.setpoint_min     = value[LIMIT_W-1:0];
            REG_SP_MAX:    limits.setpoint_max     = value[LIMIT_W-1:0];
            REG_HOLD_BAND: limits.hold_band        = value[LIMIT_W-1:0];
            REG_EMPTY:     limits.empty_pressure   = value[LIMIT_W-1:0];
            REG_DWELL:     limits.dwell_time       = value[DWELL_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic write_limits(input logic [APB_DW-1:0] arm_max, input logic [APB_DW-1:0] sp_min,
                                input logic [APB_DW-1:0] sp_max, input logic [APB_DW-1:0] band,
                                input logic [APB_DW-1:0] empty, input logic [APB_DW-1:0] dwell);
        write_reg(REG_ARM_MAX, arm_max);
        write_reg(REG_SP_MIN, sp_min);
        write_reg(REG_SP_MAX, sp_max);
        write_reg(REG_HOLD_BAND, band);
        write_reg(REG_EMPTY, empty);
        write_reg(REG_DWELL, dwell);
    endtask

    // Stop offering, wait for every predicted status word, then let the
    // pipeline settle. Registers are only touched after this.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_words != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Well-formed sequences
    // ------------------------------------------------------------------

    // Ticks that mostly satisfy a dwell condition on pressure in [lo, hi].
    // The first tick starts the timer; later ticks step the clock by half to
    // one full dwell time, so the mode advances unless a miss interrupts.
    // stale_gated: the condition also needs a fresh reading (abort recovery).
    task automatic dwell_ticks(input int lo, input int hi, input bit stale_gated);
        int count;
        int p;
        bit miss;
        bit stl;
        count = $urandom_range(3, 6);
        for (int n = 0; n < count; n++) begin
            if (n == 0)
                clock_ms += $urandom_range(0, 50);
            else
                clock_ms += $urandom_range(limits.dwell_time / 2, limits.dwell_time);
            miss = ($urandom_range(0, 9) == 0);
            p    = pick_between(lo, hi);
            stl  = stale_gated ? 1'b0 : 1'($urandom_range(0, 1));
            if (miss) begin
                if (hi < 32767)
                    p = pick_between(hi + 1, 32767);
                else if (lo > -32768)
                    p = pick_between(-32768, lo - 1);
                if (stale_gated)
                    stl = 1'b1;
            end
            offer(tick_word(p, clock_ms, 1'b0, 1'b0, stl));
        end
    endtask

    // One pass through the full life cycle: (optionally) abort and recover to
    // idle, arm, set, press, settle into hold, vent, drain to safe, clear.
    task automatic run_mission();
        int arm_lim;
        int sp_lo;
        int sp_hi;
        int band;
        arm_lim = int'(limits.arm_max_pressure);
        sp_lo   = int'(limits.setpoint_min);
        sp_hi   = int'(limits.setpoint_max);
        band    = int'(limits.hold_band);
        if ($urandom_range(0, 1) == 1) begin
            offer(cmd_word(CMD_ABORT, $urandom, $urandom, 1'($urandom_range(0, 1))));
            dwell_ticks(-32768, int'(limits.empty_pressure), 1'b1);
            offer(cmd_word(CMD_CLEAR, $urandom, pick_below(arm_lim), 1'b0));
        end
        offer(cmd_word(CMD_ARM, $urandom, pick_below(arm_lim), $urandom_range(0, 15) == 0));
        // when min > max no new setpoint can pass, so press fails on range unless one is still valid
        if (sp_lo <= sp_hi) begin
            target_sp = pick_between(sp_lo, sp_hi);
            offer(cmd_word(CMD_SET, target_sp, $urandom, 1'b0));
        end
        offer(cmd_word(CMD_PRESS, $urandom, pick_below(arm_lim), 1'b0));
        dwell_ticks(target_sp - band, target_sp + band, 1'b0);
        if ($urandom_range(0, 2) == 0)
            offer(cmd_word(CMD_SET, pick_between(sp_lo - 2, sp_hi + 2), $urandom, 1'b0));
        offer(cmd_word(CMD_VENT, $urandom, $urandom, 1'b0));
        dwell_ticks(-32768, int'(limits.empty_pressure), 1'b0);
        if ($urandom_range(0, 3) != 0)
            offer(cmd_word(CMD_CLEAR, $urandom, pick_below(arm_lim), 1'b0));
    endtask

    // Mostly full sequences, with runs of pure noise in between.
    task automatic random_phase(input int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 3) != 0)
                run_mission();
            else
                repeat ($urandom_range(1, 6)) send_word(noise_word());
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready follows a pattern that is redrawn after each random
    // span (always ready, coin flip, mostly ready, periodic). One long
    // hold-off on request makes the block back up into its input.
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int style;
        int span;
        int k;
        bit stall_served;
        style        = 0;
        span         = 0;
        k            = 0;
        stall_served = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_request && !stall_served) begin
                stall_served = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(64, 256);
            end
            span--;
            k++;
            case (style)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                2:       out_ch.ready <= ($urandom_range(0, 4) != 0);
                default: out_ch.ready <= ((k % 5) != 0);
            endcase
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        in_word_t          plan[$];
        logic [TIME_W-1:0] t_hold;
        logic [TIME_W-1:0] t_vent;
        logic [TIME_W-1:0] t_abort;
        logic [APB_DW-1:0] lo_sp;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        limits.arm_max_pressure = ARM_MAX_RST;
        limits.setpoint_min     = SP_MIN_RST;
        limits.setpoint_max     = SP_MAX_RST;
        limits.hold_band        = HOLD_BAND_RST;
        limits.empty_pressure   = EMPTY_RST;
        limits.dwell_time       = DWELL_RST;
        target_sp = int'(SP_MIN_RST);
        clock_ms  = $urandom;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass on reset limits (arm max 100, setpoint 500..1500,
        // band 50, empty 50, dwell 2000).
        t_hold  = 32'hFFFF_FC00;        // hold dwell runs across the 2^32 wrap
        t_vent  = 32'h0001_0000;
        t_abort = 32'h8000_0000;
        plan.push_back(cmd_word(CMD_UNUSED, 0, 0, 1'b0));         // unknown code
        plan.push_back(cmd_word(CMD_DISARM, 0, 0, 1'b0));         // wrong mode
        plan.push_back(cmd_word(CMD_SET, -32768, 0, 1'b0));       // far below min
        plan.push_back(cmd_word(CMD_SET, 1501, 0, 1'b0));         // just above max
        plan.push_back(cmd_word(CMD_SET, 500, 0, 1'b0));          // at min
        plan.push_back(cmd_word(CMD_ARM, 0, 100, 1'b0));          // pressure at limit
        plan.push_back(cmd_word(CMD_ARM, 0, -32768, 1'b1));       // loop fault
        plan.push_back(cmd_word(CMD_ARM, 0, 99, 1'b0));           // armed
        plan.push_back(cmd_word(CMD_DISARM, 0, 0, 1'b0));         // back to idle
        plan.push_back(cmd_word(CMD_ARM, 0, -32768, 1'b0));
        plan.push_back(cmd_word(CMD_SET, 1500, 0, 1'b0));         // at max
        plan.push_back(cmd_word(CMD_PRESS, 0, 100, 1'b0));        // pressure at limit
        plan.push_back(cmd_word(CMD_PRESS, 0, 99, 1'b0));         // pressurize
        plan.push_back(tick_word(1450, t_hold, 1'b0, 1'b0, 1'b0));        // band edge, start
        plan.push_back(tick_word(1551, t_hold + 5, 1'b0, 1'b0, 1'b0));    // out, timer stops
        plan.push_back(tick_word(1550, t_hold + 10, 1'b0, 1'b0, 1'b0));   // restart
        plan.push_back(tick_word(1500, t_hold + 2009, 1'b0, 1'b0, 1'b0)); // one ms short
        plan.push_back(tick_word(1500, t_hold + 2010, 1'b0, 1'b0, 1'b0)); // hold
        plan.push_back(cmd_word(CMD_VENT, 0, 0, 1'b0));
        plan.push_back(tick_word(50, t_vent, 1'b0, 1'b0, 1'b1));          // empty edge, start
        plan.push_back(tick_word(32767, t_vent + 5000, 1'b0, 1'b0, 1'b0)); // miss keeps timer
        plan.push_back(tick_word(-5, t_vent + 5001, 1'b0, 1'b0, 1'b0));   // safe
        plan.push_back(cmd_word(CMD_CLEAR, 0, 100, 1'b0));        // pressure at limit
        plan.push_back(cmd_word(CMD_CLEAR, 0, 99, 1'b0));         // idle, latch clear
        plan.push_back(tick_word(0, t_abort, 1'b0, 1'b1, 1'b0));  // redline in idle
        plan.push_back(tick_word(50, t_abort + 1, 1'b0, 1'b0, 1'b0));     // abort dwell start
        // redline while in abort does not interrupt the abort dwell
        plan.push_back(tick_word(0, t_abort + 2001, 1'b1, 1'b1, 1'b0));
        plan.push_back(cmd_word(CMD_ABORT, 0, 0, 1'b0));          // from safe
        plan.push_back(cmd_word(CMD_ABORT, 0, 0, 1'b0));          // re-entry
        foreach (plan[i])
            send_word(plan[i]);
        random_phase(PHASE_WORDS);
        drain();

        // All-high extremes; upper data bits set to check masking. Dwell of
        // zero advances on the second matching tick. The long status-side
        // hold-off happens in this phase.
        write_limits(32'hFFFF_FFFF, 32'hFFFF_8000, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000);
        stall_request <= 1'b1;
        random_phase(PHASE_WORDS);
        drain();

        // All-low extremes: only negative pressures pass the arm limit, the
        // band is a single value and the dwell is the longest possible.
        clock_ms = 32'hFFFE_0000;
        write_limits(32'd0, 32'd32767, 32'd32767, 32'd0, 32'd0, 32'd65535);
        random_phase(PHASE_WORDS);
        drain();

        // Random but consistent limits.
        lo_sp = $urandom_range(0, 3000);
        write_limits($urandom_range(0, 32767), lo_sp, lo_sp + $urandom_range(0, 4000),
                     $urandom_range(0, 300), $urandom_range(0, 2000), $urandom_range(0, 65535));
        random_phase(PHASE_WORDS);
        drain();

        // Fully random register words, min above max allowed.
        write_limits($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_phase(PHASE_WORDS);
        drain();

        if (fail_count == 0 && pending_words == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/psq_pkg.sv
hw/rtl/psq_in_if.sv
hw/rtl/psq_out_if.sv
hw/rtl/psq_step.sv
hw/rtl/pressurization_sequencer.sv
bench/psq_status_checker.sv
bench/pressurization_sequencer_test.sv
